### rtl/core/bmf_pkg.sv
// shared constants, payload types and state codes of the box mean filter
`default_nettype none
package bmf_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int RADIUS      = 2;
  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 16;

  localparam int LANES     = 4;
  localparam int LANE_W    = 16;
  localparam int WIN       = 2 * RADIUS + 1;
  localparam int RING_ROWS = 2 * RADIUS + 2;
  localparam int DEPTH     = RING_ROWS * MAX_WIDTH;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int DIM_W     = 11;
  localparam int ROW_W     = 11;
  localparam int RING_W    = $clog2(RING_ROWS);
  localparam int WIN_W     = $clog2(WIN);
  localparam int CNT_W     = $clog2(WIN * WIN + 1);
  localparam int SUM_W     = LANE_W + $clog2(WIN * WIN);
  localparam int STEP_W    = $clog2(SUM_W + 1);

  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [LANE_W-1:0] sample_ch0;
    logic [LANE_W-1:0] sample_ch1;
    logic [LANE_W-1:0] sample_ch2;
    logic [LANE_W-1:0] sample_ch3;
  } in_item_t;

  typedef struct packed {
    logic [LANE_W-1:0] mean_ch0;
    logic [LANE_W-1:0] mean_ch1;
    logic [LANE_W-1:0] mean_ch2;
    logic [LANE_W-1:0] mean_ch3;
    logic              last_of_frame;
  } out_item_t;

  typedef logic [LANES-1:0][SUM_W-1:0] lane_sums_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SWEEP,
    S_TAIL,
    S_DIVGO,
    S_DIV
  } state_t;

endpackage
`default_nettype wire

### rtl/core/bmf_div.sv
// bit-serial restoring divider, all lanes share one divisor
`default_nettype none
module bmf_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire bmf_pkg::lane_sums_t            num,
  input  wire logic [bmf_pkg::CNT_W-1:0]      den,
  output logic                                done,
  output bmf_pkg::lane_sums_t                 quot
);

  logic                          busy;
  logic [bmf_pkg::STEP_W-1:0]    step;
  logic [bmf_pkg::CNT_W-1:0]     d;
  logic [bmf_pkg::CNT_W-1:0]     rem [bmf_pkg::LANES];
  logic [bmf_pkg::CNT_W:0]       trial [bmf_pkg::LANES];
  logic                          fits [bmf_pkg::LANES];

  // trial subtract per lane
  always_comb begin
    for (int l = 0; l < bmf_pkg::LANES; l++) begin
      trial[l] = {rem[l], quot[l][bmf_pkg::SUM_W-1]};
      fits[l]  = trial[l] >= {1'b0, d};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == bmf_pkg::STEP_W'(bmf_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      d <= den;
      for (int l = 0; l < bmf_pkg::LANES; l++) begin
        rem[l]  <= '0;
        quot[l] <= num[l];
      end
    end else if (busy) begin
      for (int l = 0; l < bmf_pkg::LANES; l++) begin
        if (fits[l]) begin
          rem[l] <= bmf_pkg::CNT_W'(trial[l] - {1'b0, d});
        end else begin
          rem[l] <= trial[l][bmf_pkg::CNT_W-1:0];
        end
        quot[l] <= {quot[l][bmf_pkg::SUM_W-2:0], fits[l]};
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/box_mean_filter_5x5.sv
// top level of the streaming 5x5 box mean filter
`default_nettype none
// Raster-order box mean filter over four 16-bit channels. An input beat that
// releases no result is accepted and then tested for a release. A beat that
// releases a result keeps the input stalled while the sequencer tests for the
// release, reads the neighborhood through the single read port of the line
// store, runs a pipeline tail, starts the divider, waits for the bit-serial
// divider and loads the output register. The release test also holds while
// an earlier result still waits in the output register.
// A new input beat is taken while a result waits in the output register.
// Writing frame_width or frame_height restarts the frame; write only while idle.
// Drain beats (mode 1) flush the results still pending after the last pixel.
module box_mean_filter_5x5 (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire bmf_pkg::in_item_t         in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output bmf_pkg::out_item_t             out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [bmf_pkg::DIM_W-1:0] cfg_data
);

  bmf_pkg::state_t state, state_next;

  logic [bmf_pkg::DIM_W-1:0]  frame_width, frame_height;
  logic [bmf_pkg::DIM_W-1:0]  w, h;
  logic [bmf_pkg::COL_W-1:0]  in_col, out_col;
  logic [bmf_pkg::ROW_W-1:0]  in_row, out_row;
  logic [bmf_pkg::RING_W-1:0] in_ring, out_ring;
  logic [bmf_pkg::WIN_W-1:0]  dr, dc;
  logic [bmf_pkg::CNT_W-1:0]  count;
  logic                       rd_pend;
  logic                       last;
  bmf_pkg::lane_sums_t        sum, div_num, quot;
  logic                       div_done;

  logic [63:0]                line_mem [bmf_pkg::DEPTH];
  logic [63:0]                mem_q;
  logic [63:0]                packed_px;

  logic                       accept, store, cfg_wr;
  logic                       ready, issue, sweep_end;
  logic [bmf_pkg::DIM_W:0]    nr, nc;
  logic [bmf_pkg::ROW_W:0]    rr_off;
  logic [bmf_pkg::DIM_W:0]    cc_off;
  logic                       row_ok, col_ok;
  logic [bmf_pkg::RING_W+1:0] ring_tmp;
  logic [bmf_pkg::RING_W-1:0] rd_ring;
  logic [bmf_pkg::COL_W-1:0]  rd_col;
  logic [bmf_pkg::ADDR_W-1:0] rd_addr, wr_addr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = (state != bmf_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign store     = accept && !in_data.mode && (in_row < h);

  // effective frame size
  always_comb begin
    if (frame_width == '0) begin
      w = bmf_pkg::DIM_W'(1);
    end else if (frame_width > bmf_pkg::DIM_W'(bmf_pkg::MAX_WIDTH)) begin
      w = bmf_pkg::DIM_W'(bmf_pkg::MAX_WIDTH);
    end else begin
      w = frame_width;
    end
    h = (frame_height == '0) ? bmf_pkg::DIM_W'(1) : frame_height;
  end

  // incoming pixel packed into lanes
  always_comb begin
    logic [bmf_pkg::LANE_W-1:0] s [bmf_pkg::LANES];
    s[0] = in_data.sample_ch0;
    s[1] = in_data.sample_ch1;
    s[2] = in_data.sample_ch2;
    s[3] = in_data.sample_ch3;
    packed_px = '0;
    for (int l = 0; l < bmf_pkg::LANES; l++) begin
      if (l < bmf_pkg::CHANNELS) begin
        packed_px[l*bmf_pkg::LANE_W +: bmf_pkg::LANE_W] =
          s[l] & bmf_pkg::LANE_W'((32'd1 << bmf_pkg::SAMPLE_BITS) - 32'd1);
      end
    end
  end

  // result release test: last needed input pixel has arrived
  always_comb begin
    nr = {1'b0, out_row} + (bmf_pkg::DIM_W+1)'(bmf_pkg::RADIUS);
    if (nr > {1'b0, h - 1'b1}) nr = {1'b0, h - 1'b1};
    nc = (bmf_pkg::DIM_W+1)'(out_col) + (bmf_pkg::DIM_W+1)'(bmf_pkg::RADIUS);
    if (nc > {1'b0, w - 1'b1}) nc = {1'b0, w - 1'b1};
    ready = (out_row < h) &&
            ((nr < {1'b0, in_row}) ||
             ((nr == {1'b0, in_row}) && (nc < (bmf_pkg::DIM_W+1)'(in_col))));
  end

  // neighbor address for the sweep
  always_comb begin
    rr_off = {1'b0, out_row} + (bmf_pkg::ROW_W+1)'(dr);
    cc_off = (bmf_pkg::DIM_W+1)'(out_col) + (bmf_pkg::DIM_W+1)'(dc);
    row_ok = (rr_off >= (bmf_pkg::ROW_W+1)'(bmf_pkg::RADIUS)) &&
             (rr_off - (bmf_pkg::ROW_W+1)'(bmf_pkg::RADIUS) < {1'b0, h});
    col_ok = (cc_off >= (bmf_pkg::DIM_W+1)'(bmf_pkg::RADIUS)) &&
             (cc_off - (bmf_pkg::DIM_W+1)'(bmf_pkg::RADIUS) < {1'b0, w});
    rd_col = bmf_pkg::COL_W'(cc_off - (bmf_pkg::DIM_W+1)'(bmf_pkg::RADIUS));
    ring_tmp = (bmf_pkg::RING_W+2)'(out_ring) + (bmf_pkg::RING_W+2)'(dr) +
               (bmf_pkg::RING_W+2)'(bmf_pkg::RING_ROWS - bmf_pkg::RADIUS);
    if (ring_tmp >= (bmf_pkg::RING_W+2)'(2 * bmf_pkg::RING_ROWS)) begin
      ring_tmp = ring_tmp - (bmf_pkg::RING_W+2)'(2 * bmf_pkg::RING_ROWS);
    end else if (ring_tmp >= (bmf_pkg::RING_W+2)'(bmf_pkg::RING_ROWS)) begin
      ring_tmp = ring_tmp - (bmf_pkg::RING_W+2)'(bmf_pkg::RING_ROWS);
    end
    rd_ring = bmf_pkg::RING_W'(ring_tmp);
    rd_addr = bmf_pkg::ADDR_W'(rd_ring) * bmf_pkg::ADDR_W'(bmf_pkg::MAX_WIDTH) +
              bmf_pkg::ADDR_W'(rd_col);
    wr_addr = bmf_pkg::ADDR_W'(in_ring) * bmf_pkg::ADDR_W'(bmf_pkg::MAX_WIDTH) +
              bmf_pkg::ADDR_W'(in_col);
  end

  // line store
  always_ff @(posedge clk) begin
    if (store) begin
      line_mem[wr_addr] <= packed_px;
    end
    if (issue) begin
      mem_q <= line_mem[rd_addr];
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    sweep_end  = (dr == bmf_pkg::WIN_W'(bmf_pkg::WIN - 1)) &&
                 (dc == bmf_pkg::WIN_W'(bmf_pkg::WIN - 1));
    case (state)
      bmf_pkg::S_IDLE: begin
        if (accept) state_next = bmf_pkg::S_CHECK;
      end
      bmf_pkg::S_CHECK: begin
        if (!ready) begin
          state_next = bmf_pkg::S_IDLE;
        end else if (!out_valid) begin
          state_next = bmf_pkg::S_SWEEP;
        end
      end
      bmf_pkg::S_SWEEP: begin
        issue = row_ok && col_ok;
        if (sweep_end) state_next = bmf_pkg::S_TAIL;
      end
      bmf_pkg::S_TAIL: begin
        state_next = bmf_pkg::S_DIVGO;
      end
      bmf_pkg::S_DIVGO: begin
        state_next = bmf_pkg::S_DIV;
      end
      bmf_pkg::S_DIV: begin
        if (div_done) state_next = bmf_pkg::S_IDLE;
      end
      default: begin
        state_next = bmf_pkg::S_IDLE;
      end
    endcase
    if (cfg_wr) state_next = bmf_pkg::S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bmf_pkg::DIM_W'(1024);
      frame_height <= bmf_pkg::DIM_W'(1024);
    end else if (cfg_wr) begin
      case (cfg_index)
        bmf_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        bmf_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame positions
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      in_col   <= '0;
      in_row   <= '0;
      in_ring  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_ring <= '0;
    end else if (state == bmf_pkg::S_DIV && div_done && last) begin
      in_col   <= '0;
      in_row   <= '0;
      in_ring  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_ring <= '0;
    end else begin
      if (store) begin
        if ((bmf_pkg::DIM_W)'(in_col) + 1'b1 >= w) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
          in_ring <= (in_ring == bmf_pkg::RING_W'(bmf_pkg::RING_ROWS - 1)) ?
                     '0 : in_ring + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (state == bmf_pkg::S_DIV && div_done) begin
        if ((bmf_pkg::DIM_W)'(out_col) + 1'b1 >= w) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
          out_ring <= (out_ring == bmf_pkg::RING_W'(bmf_pkg::RING_ROWS - 1)) ?
                      '0 : out_ring + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  // neighborhood sweep and accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bmf_pkg::S_CHECK) begin
      dr    <= '0;
      dc    <= '0;
      count <= '0;
      sum   <= '0;
      last  <= ({1'b0, out_row} == {1'b0, h - 1'b1}) &&
               ((bmf_pkg::DIM_W)'(out_col) == w - 1'b1);
    end else begin
      if (state == bmf_pkg::S_SWEEP) begin
        if (dc == bmf_pkg::WIN_W'(bmf_pkg::WIN - 1)) begin
          dc <= '0;
          dr <= dr + 1'b1;
        end else begin
          dc <= dc + 1'b1;
        end
        if (issue) count <= count + 1'b1;
      end
      if (rd_pend) begin
        for (int l = 0; l < bmf_pkg::LANES; l++) begin
          sum[l] <= sum[l] +
                    bmf_pkg::SUM_W'(mem_q[l*bmf_pkg::LANE_W +: bmf_pkg::LANE_W]);
        end
      end
      if (state == bmf_pkg::S_DIVGO && count == '0) count <= bmf_pkg::CNT_W'(1);
    end
  end

  // rounding bias for nearest with ties up
  always_comb begin
    for (int l = 0; l < bmf_pkg::LANES; l++) begin
      div_num[l] = sum[l] + bmf_pkg::SUM_W'(count >> 1);
    end
  end

  bmf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == bmf_pkg::S_DIVGO),
    .num   (div_num),
    .den   ((count == '0) ? bmf_pkg::CNT_W'(1) : count),
    .done  (div_done),
    .quot  (quot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      out_valid <= 1'b0;
    end else if (state == bmf_pkg::S_DIV && div_done) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bmf_pkg::S_DIV && div_done) begin
      out_data.mean_ch0 <= (0 < bmf_pkg::CHANNELS) ? quot[0][bmf_pkg::LANE_W-1:0] : '0;
      out_data.mean_ch1 <= (1 < bmf_pkg::CHANNELS) ? quot[1][bmf_pkg::LANE_W-1:0] : '0;
      out_data.mean_ch2 <= (2 < bmf_pkg::CHANNELS) ? quot[2][bmf_pkg::LANE_W-1:0] : '0;
      out_data.mean_ch3 <= (3 < bmf_pkg::CHANNELS) ? quot[3][bmf_pkg::LANE_W-1:0] : '0;
      out_data.last_of_frame <= last;
    end
  end

  // a result is loaded only at the end of a division
  a_load_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == bmf_pkg::S_DIV && div_done))
    else $error("result loaded outside division end");

  // the window never counts more pixels than it holds
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bmf_pkg::S_DIV) |-> (count <= bmf_pkg::CNT_W'(bmf_pkg::WIN * bmf_pkg::WIN)))
    else $error("window count out of range");

  // a sweep only runs for a result row inside the frame
  a_sweep_row: assert property (@(posedge clk) disable iff (rst || cfg_wr)
    (state == bmf_pkg::S_SWEEP) |-> (out_row < h))
    else $error("sweep past frame end");

  // the line store is not written while a neighborhood is read
  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    issue |-> !store)
    else $error("line store written during sweep");

endmodule
`default_nettype wire
